// File: sv/seam_min_cost_dp_assert.svh
// Assertion macros for the seam cost block.
// Included by the top level; expects clk and rst in scope.
`ifndef SEAM_MIN_COST_DP_ASSERT_SVH
`define SEAM_MIN_COST_DP_ASSERT_SVH

// Same-cycle implication
`define SMCD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("seam_min_cost_dp: same-cycle check failed");

// Next-cycle implication
`define SMCD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("seam_min_cost_dp: next-cycle check failed");

`endif

// File: sv/smcd_pkg.sv
// Shared constants, types and helpers for the seam cost block.
// No dependencies.
package smcd_pkg;

  localparam int MAX_ROWS    = 1024;
  localparam int MAX_COLS    = 1024;
  localparam int ENERGY_BITS = 16;
  localparam int ENERGY_W    = 16;
  localparam int DIM_BITS    = 11;
  localparam int ROW_BITS    = $clog2(MAX_ROWS);
  localparam int COL_BITS    = $clog2(MAX_COLS) > 0 ? $clog2(MAX_COLS) : 1;
  localparam int COST_BITS   = 26;
  localparam int OUT_ROW_W   = 10;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;
  localparam int ADDR_W      = 3;

  localparam logic [COST_BITS-1:0] COST_TOP = {COST_BITS{1'b1}};

  typedef enum logic {
    REG_IMAGE_ROWS = 1'b0,
    REG_IMAGE_COLS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [ENERGY_BITS-1:0] energy;
    logic [ROW_BITS-1:0]    row;
    logic                   first_col;
    logic                   last_col;
    logic                   last_row;
    logic                   result;
  } pix_t;

  typedef struct packed {
    logic [COST_BITS-1:0] cost;
    logic [ROW_BITS-1:0]  row;
  } res_t;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                     input logic [DIM_BITS-1:0] maxv);
    logic [DIM_BITS-1:0] r;
    if (v == '0) begin
      r = DIM_BITS'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: sv/smcd_seq.sv
// Pixel sequencer: row/column counters, input stage register, line lookahead address.
// Depends on smcd_pkg.
module smcd_seq
  import smcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  fire,
  input  logic                  restart,
  input  logic [ENERGY_W-1:0]   energy,
  input  logic [DIM_BITS-1:0]   image_rows,
  input  logic [DIM_BITS-1:0]   image_cols,
  output pix_t                  pix,
  output logic                  pix_valid,
  output logic [ROW_BITS-1:0]   rd_addr
);

  logic [ROW_BITS-1:0] row_count;
  logic [COL_BITS-1:0] col_count;
  logic [DIM_BITS-1:0] rows_eff;
  logic [DIM_BITS-1:0] cols_eff;
  logic                last_row;
  logic                last_col;

  assign rows_eff = clamp_dim(image_rows, DIM_BITS'(MAX_ROWS));
  assign cols_eff = clamp_dim(image_cols, DIM_BITS'(MAX_COLS));
  assign last_row = (DIM_BITS'(row_count) == rows_eff - DIM_BITS'(1));
  assign last_col = (DIM_BITS'(col_count) == cols_eff - DIM_BITS'(1));
  assign rd_addr  = last_row ? '0 : row_count + ROW_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (last_row) begin
        row_count <= '0;
        col_count <= last_col ? '0 : col_count + COL_BITS'(1);
      end else begin
        row_count <= row_count + ROW_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (accept) begin
      pix_valid <= 1'b1;
    end else if (fire) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix.energy    <= energy[ENERGY_BITS-1:0];
      pix.row       <= row_count;
      pix.first_col <= (col_count == '0);
      pix.last_col  <= last_col;
      pix.last_row  <= last_row;
      pix.result    <= last_col && last_row;
    end
  end

endmodule

// File: sv/smcd_cost.sv
// Cost stage: cost line memory, three-neighbour minimum, saturating add, best tracking.
// Depends on smcd_pkg.
module smcd_cost
  import smcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [ROW_BITS-1:0] rd_addr,
  input  logic                fire,
  input  pix_t                pix,
  output res_t                res
);

  logic [COST_BITS-1:0] cost_line [MAX_ROWS];
  logic [COST_BITS-1:0] below_cost;
  logic [COST_BITS-1:0] here_cost;
  logic [COST_BITS-1:0] held_upper_cost;
  logic [COST_BITS-1:0] best_cost;
  logic [ROW_BITS-1:0]  best_row;
  logic [COST_BITS-1:0] m_up;
  logic [COST_BITS-1:0] m_all;
  logic [COST_BITS:0]   sum;
  logic [COST_BITS-1:0] cost;
  logic                 take_best;

  always_comb begin
    m_up = here_cost;
    if (pix.row != '0 && held_upper_cost < m_up) begin
      m_up = held_upper_cost;
    end
    m_all = m_up;
    if (!pix.last_row && below_cost < m_up) begin
      m_all = below_cost;
    end
    sum  = (COST_BITS+1)'(pix.energy) + {1'b0, m_all};
    cost = pix.first_col ? COST_BITS'(pix.energy)
         : (sum[COST_BITS] ? COST_TOP : sum[COST_BITS-1:0]);
    take_best = pix.last_col && (pix.row == '0 || cost < best_cost);
  end

  assign res.cost = take_best ? cost : best_cost;
  assign res.row  = take_best ? pix.row : best_row;

  always_ff @(posedge clk) begin
    if (fire) begin
      cost_line[pix.row] <= cost;
    end
    if (rd_en) begin
      below_cost <= (fire && pix.row == rd_addr) ? cost : cost_line[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_upper_cost <= '0;
    end else if (fire) begin
      held_upper_cost <= here_cost;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      here_cost <= (pix.last_row && pix.row == '0) ? cost : below_cost;
      if (take_best) begin
        best_cost <= cost;
        best_row  <= pix.row;
      end
    end
  end

endmodule

// File: sv/seam_min_cost_dp.sv
// Top level of the minimum-energy seam cost block: config port, handshakes, result register.
// Depends on smcd_pkg, smcd_seq, smcd_cost and seam_min_cost_dp_assert.svh.
//
// Energy pixels enter on the s_axis channel in column-major order, top row first
// within each column, one transaction per pixel (energy in s_axis_tdata[15:0]).
// After the last pixel of the last column one transaction leaves on m_axis with
// the least total seam cost and the row where that seam ends.
// Pixels are taken one per cycle unless a stalled result holds the input stage; each needs
// one lookahead read of the cost line memory, whose single read port sets that rate.
// A pixel is registered in the input stage, and when the pixel that closes the image
// fires, the cost stage result is loaded into the result register.
// image_rows (address 0) and image_cols (address 4) are written over APB; any write restarts
// the image. The user must write them only while the block is idle; it is not enforced.
// Reset sets both dimensions to 1024, clears the counters and empties both stages.
// The cost line memory is not cleared: column 0 writes it before it is read.
// When the receiver stalls, the result stays in m_axis_tdata; pixels keep being
// taken until the pixel that closes the next image waits in the input stage.
module seam_min_cost_dp
  import smcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] energy
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [25:0] seam_cost, [35:26] seam_end_row
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [DIM_BITS-1:0] image_rows;
  logic [DIM_BITS-1:0] image_cols;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;
  logic                accept;
  logic                fire;
  logic                pix_adv;
  logic                pix_valid;
  pix_t                pix;
  res_t                res;
  logic [ROW_BITS-1:0] rd_addr;
  logic [COST_BITS-1:0] out_cost;
  logic [ROW_BITS-1:0]  out_row;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= DIM_BITS'(1024);
      image_cols <= DIM_BITS'(1024);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IMAGE_ROWS: image_rows <= pwdata[DIM_BITS-1:0];
        REG_IMAGE_COLS: image_cols <= pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_IMAGE_ROWS: prdata = 32'(image_rows);
      REG_IMAGE_COLS: prdata = 32'(image_cols);
      default:        prdata = '0;
    endcase
  end

  assign pix_adv       = !pix.result || !m_axis_tvalid || m_axis_tready;
  assign fire          = pix_valid && pix_adv;
  assign s_axis_tready = !pix_valid || pix_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  smcd_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .fire       (fire),
    .restart    (cfg_wr),
    .energy     (s_axis_tdata[ENERGY_W-1:0]),
    .image_rows (image_rows),
    .image_cols (image_cols),
    .pix        (pix),
    .pix_valid  (pix_valid),
    .rd_addr    (rd_addr)
  );

  smcd_cost u_cost (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .fire    (fire),
    .pix     (pix),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire && pix.result) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && pix.result) begin
      out_cost <= res.cost;
      out_row  <= res.row;
    end
  end

  assign m_axis_tdata = {(OUT_TDATA_W-COST_BITS-OUT_ROW_W)'(0),
                         OUT_ROW_W'(out_row), out_cost};

`include "seam_min_cost_dp_assert.svh"

  `SMCD_ASSERT_IMP(a_no_result_overwrite,
    pix_valid && pix.result && m_axis_tvalid && !m_axis_tready, !fire && !s_axis_tready)
  `SMCD_ASSERT_NXT(a_result_loaded, fire && pix.result, m_axis_tvalid)
  `SMCD_ASSERT_NXT(a_stage_holds, pix_valid && !fire, pix_valid && $stable(pix))

endmodule
